// ===== rtl/core/rde_pkg.sv =====
// rde_pkg: shared types and codes for the radix digit emitter
// holds radix mode codes, digit cell operations and the cell control struct
// no dependencies
`default_nettype none

package rde_pkg;

  localparam int DIGIT_W = 4;
  localparam int MODE_W  = 2;

  // radix selection codes
  localparam logic [MODE_W-1:0] MODE_BIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OCT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BCD = 2'd3;

  // digit cell operations
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_CONV  = 2'd2;
  localparam logic [1:0] OP_SHIFT = 2'd3;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [MODE_W-1:0] mode;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/radix_digit_emitter.sv =====
// radix_digit_emitter: value to binary, octal, hex or bcd digits, msd first
// steps: the value is fed bit by bit into the cell row, leading zero digits are
// shifted out, then digits are handed out msd first, one digit per cycle while
// out_stall is low; an output stall holds the current digit
// one request in flight at a time, set by the serial bit feed through the cell row
// reset (rst, synchronous) returns the controller to idle; digit cells need none
`default_nettype none

module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input requests
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic [MODE_W-1:0]     mode,
  // output digits
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output digit_t                     digit,
  output logic                       last
);

  // one cell per possible digit: binary needs the most
  localparam int NCELL = VALUE_BITS;
  localparam int CW    = $clog2(VALUE_BITS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(VALUE_BITS);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [VALUE_BITS-1:0] value_sr;
  logic [MODE_W-1:0]     mode_r;
  logic                  in_take;
  cell_ctrl_t            ctrl;

  logic   [NCELL-1:0] carry;
  digit_t             cell_d [NCELL];
  digit_t             top;

  assign in_take   = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign top       = cell_d[NCELL-1];
  assign out_valid = (state == ST_EMIT);
  assign digit     = top;
  assign last      = (cnt == CNT_ONE);

  // controller: feed bits, drop leading zeros, then hand out digits
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctrl.mode  = mode_r;
    ctrl.op    = OP_HOLD;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          ctrl.op    = OP_CLEAR;
          cnt_next   = CNT_FULL;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.op  = OP_CONV;
        cnt_next = cnt - CNT_ONE;
        if (cnt == CNT_ONE) begin
          cnt_next   = CNT_FULL;
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // a zero value keeps its last digit
        if (top == '0 && cnt != CNT_ONE) begin
          ctrl.op  = OP_SHIFT;
          cnt_next = cnt - CNT_ONE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      default: begin
        if (!out_stall) begin
          if (cnt == CNT_ONE) begin
            state_next = ST_IDLE;
          end else begin
            ctrl.op  = OP_SHIFT;
            cnt_next = cnt - CNT_ONE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // input value is fed msb first into the lowest cell
  always_ff @(posedge clk) begin
    if (in_take) begin
      value_sr <= value;
      mode_r   <= mode;
    end else if (state == ST_CONV) begin
      value_sr <= {value_sr[VALUE_BITS-2:0], 1'b0};
    end
  end

  // cell row: cell 0 holds the least significant digit, the top cell the msd
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic   cin_i;
    digit_t din_i;
    if (i == 0) begin : g_first
      assign cin_i = value_sr[VALUE_BITS-1];
      assign din_i = '0;
    end else begin : g_rest
      assign cin_i = carry[i-1];
      assign din_i = cell_d[i-1];
    end
    rde_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .cin  (cin_i),
      .din  (din_i),
      .cout (carry[i]),
      .dout (cell_d[i])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/core/rde_cell.sv =====
// rde_cell: one digit position of the conversion chain
// shift-and-adjust during conversion, plain digit shift during output
// depends on rde_pkg
`default_nettype none

module rde_cell
  import rde_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       cin,
  input  wire digit_t     din,
  output logic            cout,
  output digit_t          dout
);

  digit_t digit;
  digit_t digit_next;
  digit_t adj;
  digit_t dmask;
  digit_t shifted;

  always_comb begin
    // digit width per radix
    unique case (ctrl.mode)
      MODE_BIN: dmask = 4'b0001;
      MODE_OCT: dmask = 4'b0111;
      default:  dmask = 4'b1111;
    endcase
    // add-3 correction keeps each bcd digit in range after the doubling
    if (ctrl.mode == MODE_BCD && digit >= 4'd5) begin
      adj = digit + 4'd3;
    end else begin
      adj = digit;
    end
    shifted = {adj[DIGIT_W-2:0], cin} & dmask;
    unique case (ctrl.mode)
      MODE_BIN: cout = adj[0];
      MODE_OCT: cout = adj[2];
      default:  cout = adj[3];
    endcase
  end

  always_comb begin
    unique case (ctrl.op)
      OP_CLEAR: digit_next = '0;
      OP_CONV:  digit_next = shifted;
      OP_SHIFT: digit_next = din;
      default:  digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

  assign dout = digit;

endmodule

`default_nettype wire
